// File: rtl/bpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bidirectional pair table package
// Shared types and codes for the pair table: stored entry layout, compare
// results, action and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package bpt_pkg;

    localparam int KEY_W   = 32;
    localparam int ACT_W   = 3;
    localparam int CNT_O_W = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD       = 3'd0,
        ACT_LOOK_LEFT = 3'd1,
        ACT_LOOK_RIGHT = 3'd2,
        ACT_REM_LEFT  = 3'd3,
        ACT_REM_RIGHT = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] left;
        logic [KEY_W-1:0] right;
    } entry_t;

    typedef struct packed {
        logic             hit;
        logic             free;
        logic [KEY_W-1:0] partner;
    } match_t;

endpackage
`default_nettype wire

// File: rtl/bpt_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pair table entry memory
// One write port and one registered read port holding the valid flag and
// both keys of every table entry.
// ----------------------------------------------------------------------------
module bpt_store #(
    parameter int DEPTH = 64
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire bpt_pkg::entry_t            wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output bpt_pkg::entry_t                 rd_data
);

    bpt_pkg::entry_t mem [DEPTH];
    bpt_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: rtl/bpt_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pair table key compare unit
// Compares one stored entry against the keys of the current beat and
// reports a hit, a free entry and the partner key.
// ----------------------------------------------------------------------------
module bpt_match (
    input  wire bpt_pkg::entry_t                 entry,
    input  wire logic [bpt_pkg::ACT_W-1:0]       action,
    input  wire logic [bpt_pkg::KEY_W-1:0]       key_left,
    input  wire logic [bpt_pkg::KEY_W-1:0]       key_right,
    output bpt_pkg::match_t                      result
);

    logic left_eq;
    logic right_eq;
    logic by_right;

    assign left_eq  = (entry.left == key_left);
    assign right_eq = (entry.right == key_right);
    assign by_right = (action == bpt_pkg::ACT_LOOK_RIGHT) ||
                      (action == bpt_pkg::ACT_REM_RIGHT);

    always_comb
    begin
        result.free    = !entry.valid;
        result.partner = by_right ? entry.left : entry.right;
        case (action)
            bpt_pkg::ACT_ADD:
            begin
                result.hit = entry.valid && (left_eq || right_eq);
            end
            bpt_pkg::ACT_LOOK_LEFT, bpt_pkg::ACT_REM_LEFT:
            begin
                result.hit = entry.valid && left_eq;
            end
            bpt_pkg::ACT_LOOK_RIGHT, bpt_pkg::ACT_REM_RIGHT:
            begin
                result.hit = entry.valid && right_eq;
            end
            default:
            begin
                result.hit = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/bpt_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pair table sequencer
// Clears the memory after reset, then scans it one entry per cycle for each
// beat with a valid action code, feeding the compare unit and deciding the result and the write.
// ----------------------------------------------------------------------------
module bpt_seq #(
    parameter int CAPACITY = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [bpt_pkg::ACT_W-1:0]       action,
    input  wire logic [bpt_pkg::KEY_W-1:0]       key_left,
    input  wire logic [bpt_pkg::KEY_W-1:0]       key_right,
    output logic                                 busy,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic [bpt_pkg::KEY_W-1:0]            partner_key,
    output logic [bpt_pkg::CNT_O_W-1:0]          pair_count,
    output logic                                 wr_en,
    output logic [$clog2(CAPACITY)-1:0]          wr_addr,
    output bpt_pkg::entry_t                      wr_data,
    output logic                                 rd_en,
    output logic [$clog2(CAPACITY)-1:0]          rd_addr,
    input  wire bpt_pkg::entry_t                 rd_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    bpt_pkg::state_t             state_reg, state_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic                        issue_last_reg, issue_last_next;
    logic                        chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]            chk_idx_reg, chk_idx_next;
    logic                        free_found_reg, free_found_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic [bpt_pkg::ACT_W-1:0]   act_reg, act_next;
    logic [bpt_pkg::KEY_W-1:0]   kl_reg, kl_next;
    logic [bpt_pkg::KEY_W-1:0]   kr_reg, kr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    bpt_pkg::status_t            status_reg, status_next;
    logic [bpt_pkg::KEY_W-1:0]   partner_reg, partner_next;
    logic                        done_reg, done_next;

    bpt_pkg::match_t             match;
    logic                        is_add;
    logic                        is_remove;
    logic                        free_now;
    logic [IDX_W-1:0]            free_idx_now;

    bpt_match u_match (
        .entry     (rd_data),
        .action    (act_reg),
        .key_left  (kl_reg),
        .key_right (kr_reg),
        .result    (match)
    );

    assign is_add    = (act_reg == bpt_pkg::ACT_ADD);
    assign is_remove = (act_reg == bpt_pkg::ACT_REM_LEFT) ||
                       (act_reg == bpt_pkg::ACT_REM_RIGHT);
    assign free_now     = free_found_reg || (chk_vld_reg && match.free);
    assign free_idx_now = free_found_reg ? free_idx_reg : chk_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bpt_pkg::S_CLEAR;
            idx_reg        <= '0;
            issue_last_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issue_last_reg <= issue_last_next;
            chk_vld_reg    <= chk_vld_next;
            free_found_reg <= free_found_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        free_idx_reg <= free_idx_next;
        act_reg      <= act_next;
        kl_reg       <= kl_next;
        kr_reg       <= kr_next;
        status_reg   <= status_next;
        partner_reg  <= partner_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issue_last_next = issue_last_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        act_next        = act_reg;
        kl_next         = kl_reg;
        kr_next         = kr_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        partner_next    = partner_reg;
        done_next       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = chk_idx_reg;
        wr_data         = '0;

        case (state_reg)
            bpt_pkg::S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = bpt_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            bpt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    act_next        = action;
                    kl_next         = key_left;
                    kr_next         = key_right;
                    idx_next        = '0;
                    issue_last_next = 1'b0;
                    chk_vld_next    = 1'b0;
                    free_found_next = 1'b0;
                    if (action > bpt_pkg::ACT_REM_RIGHT)
                    begin
                        done_next    = 1'b1;
                        status_next  = bpt_pkg::ST_OK;
                        partner_next = '0;
                    end
                    else
                    begin
                        state_next = bpt_pkg::S_SCAN;
                    end
                end
            end
            bpt_pkg::S_SCAN:
            begin
                rd_en        = !issue_last_reg;
                chk_vld_next = !issue_last_reg;
                chk_idx_next = idx_reg;
                if (!issue_last_reg)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_last_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (chk_vld_reg && match.free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = chk_idx_reg;
                end
                if (chk_vld_reg && match.hit)
                begin
                    state_next = bpt_pkg::S_IDLE;
                    done_next  = 1'b1;
                    if (is_add)
                    begin
                        status_next  = bpt_pkg::ST_DUP;
                        partner_next = '0;
                    end
                    else
                    begin
                        status_next  = bpt_pkg::ST_OK;
                        partner_next = match.partner;
                        if (is_remove)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = chk_idx_reg;
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                else if (chk_vld_reg && (chk_idx_reg == LAST_IDX))
                begin
                    state_next   = bpt_pkg::S_IDLE;
                    done_next    = 1'b1;
                    partner_next = '0;
                    if (is_add)
                    begin
                        if (free_now)
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = free_idx_now;
                            wr_data.valid = 1'b1;
                            wr_data.left  = kl_reg;
                            wr_data.right = kr_reg;
                            count_next    = count_reg + 1'b1;
                            status_next   = bpt_pkg::ST_OK;
                        end
                        else
                        begin
                            status_next = bpt_pkg::ST_FULL;
                        end
                    end
                    else
                    begin
                        status_next = bpt_pkg::ST_MISSING;
                    end
                end
            end
            default:
            begin
                state_next = bpt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != bpt_pkg::S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign partner_key = partner_reg;
    assign pair_count  = bpt_pkg::CNT_O_W'(count_reg);

endmodule
`default_nettype wire

// File: rtl/bidirectional_pair_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bidirectional pair table
// One-to-one table of left/right 32-bit key pairs with add, lookup and
// remove from either side, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// After reset the block clears its entry memory, one entry per cycle, and
// holds busy high meanwhile. A beat is taken when start is high and busy
// is low; for a valid action code busy then stays high while the single
// read port of the entry memory is walked one entry per cycle through the
// shared key compare. An add that is stored or refused as full, and any
// lookup or removal that misses, walks every entry; a lookup or removal
// that finds its key in entry i, or an add refused because entry i
// already holds one of its keys, ends the walk at entry i. Action codes
// above remove-by-right are answered without a scan, with busy low. The
// result appears with done high for exactly one cycle, for a scanned beat
// the cycle in which busy falls; it is not held, so the receiver must take
// it in that cycle. A new beat may be started in that same cycle.
// ----------------------------------------------------------------------------
module bidirectional_pair_table #(
    parameter int CAPACITY = 64
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [2:0]              action,
    input  wire logic signed [31:0]      key_left,
    input  wire logic signed [31:0]      key_right,
    output logic                         done,
    output logic [1:0]                   status,
    output logic signed [31:0]           partner_key,
    output logic [6:0]                   pair_count
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    bpt_pkg::entry_t         wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    bpt_pkg::entry_t         rd_data;
    logic [31:0]             partner_bits;

    bpt_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bpt_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .key_left    (key_left),
        .key_right   (key_right),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .partner_key (partner_bits),
        .pair_count  (pair_count),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    assign partner_key = signed'(partner_bits);

endmodule
`default_nettype wire

// File: bench/pair_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair table checker
// Watches the command and result channels of the pair table. For each
// accepted beat it updates its own copy of the table and queues the reply
// that the beat should produce. It compares every done strobe against the
// oldest queued reply, and it reports the number of replies still owed and
// the number of failures seen.
// ----------------------------------------------------------------------------
module pair_table_checker #(
    parameter int CAPACITY = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [2:0]         action,
    input  wire logic signed [31:0] key_left,
    input  wire logic signed [31:0] key_right,
    input  wire logic               done,
    input  wire logic [1:0]         status,
    input  wire logic signed [31:0] partner_key,
    input  wire logic [6:0]         pair_count,
    output int                      outstanding,
    output int                      failures
);

    typedef struct packed {
        bpt_pkg::status_t status;
        logic [31:0]      partner;
        logic [6:0]       count;
    } pair_reply_t;

    logic        slot_used  [CAPACITY];
    logic [31:0] slot_left  [CAPACITY];
    logic [31:0] slot_right [CAPACITY];
    int          pairs_held;
    pair_reply_t replies_due [$];
    int          reported;

    function automatic int find_key(input logic by_right, input logic [31:0] key);
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (slot_used[i] && ((by_right ? slot_right[i] : slot_left[i]) == key))
            begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic show_mismatch(input pair_reply_t due, input pair_reply_t seen);
        $display("Mismatch exp/got: status %0d/%0d partner %0d/%0d count %0d/%0d",
                 due.status, seen.status, $signed(due.partner),
                 $signed(seen.partner), due.count, seen.count);
    endtask

    function automatic pair_reply_t apply_item(input logic [2:0] act,
                                               input logic [31:0] kl,
                                               input logic [31:0] kr);
        pair_reply_t reply;
        int          slot;
        logic        by_right;
        reply = '{bpt_pkg::ST_OK, 32'd0, 7'd0};
        case (act)
            bpt_pkg::ACT_ADD:
            begin
                if (find_key(1'b0, kl) >= 0 || find_key(1'b1, kr) >= 0)
                begin
                    reply.status = bpt_pkg::ST_DUP;
                end
                else
                begin
                    slot = -1;
                    for (int i = CAPACITY - 1; i >= 0; i--)
                    begin
                        if (!slot_used[i])
                        begin
                            slot = i;
                        end
                    end
                    if (slot < 0)
                    begin
                        reply.status = bpt_pkg::ST_FULL;
                    end
                    else
                    begin
                        slot_used[slot]  = 1'b1;
                        slot_left[slot]  = kl;
                        slot_right[slot] = kr;
                        pairs_held++;
                    end
                end
            end
            bpt_pkg::ACT_LOOK_LEFT, bpt_pkg::ACT_LOOK_RIGHT,
            bpt_pkg::ACT_REM_LEFT, bpt_pkg::ACT_REM_RIGHT:
            begin
                by_right = (act == bpt_pkg::ACT_LOOK_RIGHT) ||
                           (act == bpt_pkg::ACT_REM_RIGHT);
                slot = find_key(by_right, by_right ? kr : kl);
                if (slot < 0)
                begin
                    reply.status = bpt_pkg::ST_MISSING;
                end
                else
                begin
                    reply.partner = by_right ? slot_left[slot] : slot_right[slot];
                    if (act == bpt_pkg::ACT_REM_LEFT || act == bpt_pkg::ACT_REM_RIGHT)
                    begin
                        slot_used[slot] = 1'b0;
                        pairs_held--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        reply.count = pairs_held[6:0];
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pair_reply_t due;
        pair_reply_t seen;
        int          new_fail;
        int          delta;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_used[i] = 1'b0;
            end
            pairs_held = 0;
            replies_due.delete();
            reported = 0;
            outstanding <= 0;
            failures <= 0;
        end
        else
        begin
            new_fail = 0;
            delta = 0;
            if (done)
            begin
                seen = '{bpt_pkg::status_t'(status), partner_key, pair_count};
                if (replies_due.size() == 0)
                begin
                    new_fail++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("Unexpected result: status %0d partner %0d count %0d",
                                 seen.status, $signed(seen.partner), seen.count);
                    end
                end
                else
                begin
                    due = replies_due.pop_front();
                    delta--;
                    if (seen !== due)
                    begin
                        new_fail++;
                        if (reported < 10)
                        begin
                            reported++;
                            show_mismatch(due, seen);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                replies_due.push_back(apply_item(action, key_left, key_right));
                delta++;
            end
            outstanding <= outstanding + delta;
            failures <= failures + new_fail;
        end
    end

endmodule

// File: bench/tb_bidirectional_pair_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair table testbench
// Drives add, lookup and remove commands into the pair table: a directed
// opening over key extremes, duplicates, misses and ignored codes, then
// rounds of random traffic that fill, churn and drain the table under
// varying sender gaps. A separate checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_bidirectional_pair_table;

    localparam int          CAPACITY  = 64;
    localparam logic [31:0] KEY_MIN   = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX   = 32'h7fff_ffff;
    localparam int          ROUNDS    = 11;
    localparam int          PER_ROUND = 100;
    localparam int          MIX_FILL  = 0;
    localparam int          MIX_EVEN  = 1;
    localparam int          MIX_DRAIN = 2;
    localparam int          MIX_LOOK  = 3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         action = bpt_pkg::ACT_ADD;
    logic signed [31:0] key_left = '0;
    logic signed [31:0] key_right = '0;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] partner_key;
    logic [6:0]         pair_count;
    int                 outstanding;
    int                 failures;
    int                 idle_pct = 0;
    logic [31:0]        added_left [$];
    logic [31:0]        added_right [$];

    always #1 clk = ~clk;

    bidirectional_pair_table #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .key_left(key_left),
        .key_right(key_right),
        .done(done),
        .status(status),
        .partner_key(partner_key),
        .pair_count(pair_count)
    );

    pair_table_checker #(
        .CAPACITY(CAPACITY)
    ) u_pair_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .key_left(key_left),
        .key_right(key_right),
        .done(done),
        .status(status),
        .partner_key(partner_key),
        .pair_count(pair_count),
        .outstanding(outstanding),
        .failures(failures)
    );

    function automatic logic [31:0] any_key();
        case ($urandom_range(0, 9))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return 32'd0;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] known_key(input logic right_side);
        if (right_side)
        begin
            if (added_right.size() == 0)
            begin
                return any_key();
            end
            return added_right[$urandom_range(0, added_right.size() - 1)];
        end
        if (added_left.size() == 0)
        begin
            return any_key();
        end
        return added_left[$urandom_range(0, added_left.size() - 1)];
    endfunction

    task automatic offer(input logic [2:0] act, input logic [31:0] kl,
                         input logic [31:0] kr);
        start <= 1'b1;
        action <= act;
        key_left <= kl;
        key_right <= kr;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic hold_off();
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(1, 80);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_round(input int mix);
        int          add_w;
        int          look_w;
        int          pick;
        int          sent;
        logic [2:0]  act;
        logic [31:0] kl;
        logic [31:0] kr;
        case (mix)
            MIX_FILL:
            begin
                add_w = 85;
                look_w = 7;
            end
            MIX_DRAIN:
            begin
                add_w = 10;
                look_w = 20;
            end
            MIX_LOOK:
            begin
                add_w = 15;
                look_w = 70;
            end
            default:
            begin
                add_w = 40;
                look_w = 30;
            end
        endcase
        sent = 0;
        while (sent < PER_ROUND)
        begin
            pick = $urandom_range(0, 99);
            kl = any_key();
            kr = any_key();
            if (pick < 3)
            begin
                act = 3'(bpt_pkg::ACT_REM_RIGHT) + 3'($urandom_range(1, 3));
            end
            else if (pick < 3 + add_w)
            begin
                act = bpt_pkg::ACT_ADD;
                case ($urandom_range(0, 11))
                    0: kl = known_key(1'b0);
                    1: kr = known_key(1'b1);
                    2:
                    begin
                        kl = known_key(1'b0);
                        kr = known_key(1'b1);
                    end
                    default:
                    begin
                        kl = $urandom;
                        kr = $urandom;
                    end
                endcase
            end
            else if (pick < 3 + add_w + look_w)
            begin
                act = $urandom_range(0, 1) ? bpt_pkg::ACT_LOOK_RIGHT : bpt_pkg::ACT_LOOK_LEFT;
            end
            else
            begin
                act = $urandom_range(0, 1) ? bpt_pkg::ACT_REM_RIGHT : bpt_pkg::ACT_REM_LEFT;
            end
            if (act != bpt_pkg::ACT_ADD && act <= bpt_pkg::ACT_REM_RIGHT &&
                $urandom_range(0, 4) != 0)
            begin
                if (act == bpt_pkg::ACT_LOOK_RIGHT || act == bpt_pkg::ACT_REM_RIGHT)
                begin
                    kr = known_key(1'b1);
                end
                else
                begin
                    kl = known_key(1'b0);
                end
            end
            hold_off();
            offer(act, kl, kr);
            if (act == bpt_pkg::ACT_ADD)
            begin
                added_left.push_back(kl);
                added_right.push_back(kr);
                if (added_left.size() > 96)
                begin
                    void'(added_left.pop_front());
                    void'(added_right.pop_front());
                end
            end
            if (act <= bpt_pkg::ACT_REM_RIGHT)
            begin
                sent++;
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        int mixes [ROUNDS];
        int pcts  [ROUNDS];
        mixes = '{MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_EVEN, MIX_FILL, MIX_LOOK,
                  MIX_DRAIN, MIX_EVEN, MIX_FILL, MIX_DRAIN, MIX_EVEN};
        pcts  = '{0, 77, 36, 0, 77, 36, 0, 77, 36, 77, 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        offer(bpt_pkg::ACT_ADD, KEY_MIN, KEY_MAX);
        offer(bpt_pkg::ACT_ADD, KEY_MAX, KEY_MIN);
        offer(bpt_pkg::ACT_ADD, 32'd0, 32'd0);
        offer(bpt_pkg::ACT_ADD, 32'hffff_ffff, 32'd1);
        offer(bpt_pkg::ACT_ADD, KEY_MIN, 32'd5);
        offer(bpt_pkg::ACT_ADD, 32'd7, KEY_MAX);
        offer(bpt_pkg::ACT_ADD, 32'd0, 32'd0);
        offer(bpt_pkg::ACT_LOOK_LEFT, KEY_MIN, 32'd9);
        offer(bpt_pkg::ACT_LOOK_RIGHT, 32'd9, KEY_MIN);
        offer(bpt_pkg::ACT_LOOK_LEFT, 32'd12345, 32'd0);
        offer(bpt_pkg::ACT_LOOK_RIGHT, 32'd1, 32'hffff_ffff);
        offer(bpt_pkg::ACT_LOOK_RIGHT, 32'd1, 32'hffff_ffff);
        offer(3'(bpt_pkg::ACT_REM_RIGHT) + 3'd1, KEY_MIN, KEY_MAX);
        offer(3'(bpt_pkg::ACT_REM_RIGHT) + 3'd2, 32'd0, 32'd0);
        offer(3'(bpt_pkg::ACT_REM_RIGHT) + 3'd3, KEY_MAX, KEY_MIN);
        offer(bpt_pkg::ACT_REM_RIGHT, 32'd3, 32'd1);
        offer(bpt_pkg::ACT_REM_LEFT, 32'hffff_ffff, 32'd1);
        offer(bpt_pkg::ACT_REM_RIGHT, 32'd0, 32'd0);
        offer(bpt_pkg::ACT_REM_LEFT, 32'd0, 32'd0);
        offer(bpt_pkg::ACT_REM_LEFT, KEY_MAX, 32'd0);
        offer(bpt_pkg::ACT_LOOK_RIGHT, 32'd0, KEY_MIN);
        offer(bpt_pkg::ACT_REM_RIGHT, 32'd0, KEY_MAX);
        offer(bpt_pkg::ACT_REM_LEFT, KEY_MIN, 32'd0);
        offer(bpt_pkg::ACT_ADD, 32'd3, 32'd4);
        wait_for_results();

        for (int r = 0; r < ROUNDS; r++)
        begin
            idle_pct = pcts[r];
            run_round(mixes[r]);
        end

        repeat (CAPACITY + 8) @(posedge clk);
        if (failures == 0 && outstanding == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: bidirectional_pair_table.f
rtl/bpt_pkg.sv
rtl/bpt_store.sv
rtl/bpt_match.sv
rtl/bpt_seq.sv
rtl/bidirectional_pair_table.sv
bench/pair_table_checker.sv
bench/tb_bidirectional_pair_table.sv
